@@ src/assert_macros.svh @@
// Assertion macros for the correlated feature pair selector.
// Included by the top level; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define CFPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled in reset
`define CFPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ src/cfps_pkg.sv @@
// Package for the correlated feature pair selector.
// Action codes, state encoding, register indexes and defaults; no dependencies.
package cfps_pkg;

    localparam int MAX_FEATURES_DEF = 32;
    localparam int VALUE_BITS_DEF   = 32;
    localparam int FRAC_BITS        = 16;
    localparam int ACC_BITS         = 64;
    localparam int CNT_BITS         = 16;
    localparam int FC_BITS          = 6;
    localparam int FEAT_BITS        = 5;
    localparam int PAIR_BITS        = 6;

    localparam logic [FC_BITS-1:0]  FEATURE_COUNT_RESET = 6'd32;
    localparam logic [CNT_BITS-1:0] SAMPLE_COUNT_RESET  = 16'd1;

    // Register index (paddr bit 2)
    localparam logic REG_FEATURE_COUNT = 1'b0;
    localparam logic REG_SAMPLE_COUNT  = 1'b1;

    typedef enum logic [2:0] {
        ACT_LOAD   = 3'd0,
        ACT_BATCH  = 3'd1,
        ACT_TARGET = 3'd2,
        ACT_SAMPLE = 3'd3,
        ACT_FINISH = 3'd4
    } action_t;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_SMP_MUL,
        ST_SMP_ADD,
        ST_FD_RD,
        ST_FD_LD,
        ST_FD_DIV,
        ST_FD_WR,
        ST_W_RD1,
        ST_W_LD1,
        ST_W_RD2,
        ST_W_CHK,
        ST_W_OVF,
        ST_W_DIV,
        ST_W_CMP,
        ST_DONE
    } state_t;

endpackage

@@ src/correlated_feature_pair_selector_top.sv @@
// Top level of the correlated feature pair selector: memories, sequencer, dividers.
// Depends on cfps_pkg and assert_macros.svh.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid, in_stall, action .. spread      | in
//  result   | out_valid, out_stall, best_first .. score | out
//  config   | psel, penable, pwrite, paddr, pwdata ...  | in/out
//
// Load, batch-less target start and unused actions are done in the idle state; a sample runs
// an accumulator read, a multiply, then a saturating add and write back.
// Start batch and reset run a clearing pass over all MAX_FEATURES^2 entries of the used map.
// Finish: per feature a read, a load, the 64-step covariance divider and a write; then
// per pair a read, check and compare if used, also an overflow check if the score is zero
// or saturates, else the bit-serial score divider too; a read and load each time the first feature moves on.
// in_stall is high whenever the sequencer is not idle; a result waits in its
// output register and only a finish needing the slot waits for out_stall.
`include "assert_macros.svh"

module correlated_feature_pair_selector_top #(
    parameter int MAX_FEATURES = cfps_pkg::MAX_FEATURES_DEF,
    parameter int VALUE_BITS   = cfps_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input items
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    action,
    input  logic [cfps_pkg::FEAT_BITS-1:0] feature_a,
    input  logic [cfps_pkg::FEAT_BITS-1:0] feature_b,
    input  logic [VALUE_BITS-1:0]         pair_spread,
    input  logic signed [VALUE_BITS-1:0]  feature_value,
    input  logic signed [VALUE_BITS-1:0]  target_value,
    input  logic signed [VALUE_BITS-1:0]  target_mean,
    input  logic [VALUE_BITS-1:0]         target_spread,
    // result items
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cfps_pkg::PAIR_BITS-1:0] best_first,
    output logic [cfps_pkg::PAIR_BITS-1:0] best_second,
    output logic signed [VALUE_BITS-1:0]  best_score,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int VB  = VALUE_BITS;
    localparam int AB  = cfps_pkg::ACC_BITS;
    localparam int FW  = (MAX_FEATURES > 2) ? $clog2(MAX_FEATURES) : 1;
    localparam int FD  = 2 ** FW;
    localparam int CW  = $clog2(MAX_FEATURES + 1);
    localparam int TD  = MAX_FEATURES * MAX_FEATURES;
    localparam int TW  = $clog2(TD);
    localparam int AW  = FW + 1;
    localparam int AD  = 2 * FD;
    localparam int DW  = 2 * VB;
    localparam int NW  = AB + cfps_pkg::FRAC_BITS;
    localparam int RW  = ((NW > DW) ? NW : DW) + 1;
    localparam int PW  = 2 * VB + 1;
    localparam int XW  = (PW > AB) ? PW : AB + 1;
    localparam int QW  = VB - 1;
    localparam int SW  = $clog2(AB);
    localparam int CB  = cfps_pkg::CNT_BITS;

    // ---------------- registers ----------------
    cfps_pkg::state_t state_reg, state_next;
    logic [cfps_pkg::FC_BITS-1:0] feature_count_reg;
    logic [CB-1:0]                sample_count_reg;
    logic signed [VB-1:0]         mean_reg, mean_next;
    logic [VB-1:0]                tspread_reg, tspread_next;
    logic [FD-1:0]                acc_vld_reg, acc_vld_next;
    logic [TW-1:0]                clr_reg, clr_next;
    logic [CW-1:0]                f1_reg, f1_next, f2_reg, f2_next;
    logic [SW-1:0]                step_reg, step_next;
    logic                         out_valid_reg, out_valid_next;

    logic [FW-1:0]                smp_f_reg, smp_f_next;
    logic signed [VB-1:0]         fv_reg, fv_next;
    logic signed [VB:0]           d_reg, d_next;
    logic signed [AB-1:0]         prod_reg, prod_next;
    logic [AB-1:0]                dq_reg, dq_next;
    logic [CB-1:0]                drem_reg, drem_next;
    logic                         dneg_reg, dneg_next;
    logic signed [AB-1:0]         cov_a_reg, cov_a_next;
    logic [AB-1:0]                m_reg, m_next;
    logic                         neg_reg, neg_next;
    logic [DW-1:0]                den_reg, den_next;
    logic [RW-1:0]                rem_reg, rem_next;
    logic [QW-1:0]                nlo_reg, nlo_next;
    logic [QW-1:0]                q_reg, q_next;
    logic signed [VB-1:0]         score_reg, score_next;
    logic signed [VB-1:0]         best_reg, best_next;
    logic [cfps_pkg::PAIR_BITS-1:0] bf_reg, bf_next, bs_reg, bs_next;
    logic [cfps_pkg::PAIR_BITS-1:0] best_first_reg, best_first_next;
    logic [cfps_pkg::PAIR_BITS-1:0] best_second_reg, best_second_next;
    logic signed [VB-1:0]         best_score_reg, best_score_next;

    // ---------------- memories ----------------
    logic [VB-1:0]  spread_mem [TD];
    logic           used_mem [TD];
    logic [AB-1:0]  acc_mem [AD];

    logic           sp_we;
    logic [TW-1:0]  sp_waddr, mem_raddr;
    logic           used_we, used_wdata;
    logic [TW-1:0]  used_waddr;
    logic           acc_we;
    logic [AW-1:0]  acc_waddr, acc_raddr;
    logic [AB-1:0]  acc_wdata;
    logic [VB-1:0]  spread_rd_reg;
    logic           used_rd_reg;
    logic [AB-1:0]  acc_rd_reg;
    logic           acc_rvld_reg;

    // ---------------- helpers ----------------
    logic              accept;
    logic [CW-1:0]     fc_eff;
    logic [FW-1:0]     fa_idx, fb_idx;
    logic              load_ok, smp_ok;
    logic [TW-1:0]     load_addr, pair_addr;
    logic [CB-1:0]     sdiv;
    logic signed [PW-1:0] prod_full;
    logic signed [XW-1:0] prod_x;
    logic signed [AB-1:0] acc_cur;
    logic signed [AB:0]   sum_x;
    logic [CB:0]       fd_trial;
    logic              fd_bit;
    logic [NW-1:0]     n_full;
    logic [RW-1:0]     n_hi;
    logic [RW-1:0]     w_trial;
    logic              w_bit;
    logic [QW-1:0]     q_new;
    logic              take;
    logic [CW:0]       f1_p1, f1_p2, f2_p1;
    logic [AB-1:0]     cov_b;
    logic              at_done, at_chk;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != cfps_pkg::ST_IDLE);
    assign fc_eff   = (32'(feature_count_reg) > 32'(MAX_FEATURES))
                      ? CW'(MAX_FEATURES) : CW'(feature_count_reg);
    assign fa_idx   = FW'(feature_a);
    assign fb_idx   = FW'(feature_b);
    assign load_ok  = (32'(feature_a) < 32'(MAX_FEATURES)) &&
                      (32'(feature_b) < 32'(MAX_FEATURES));
    assign smp_ok   = (32'(feature_a) < 32'(fc_eff));
    assign load_addr = TW'(TW'(fa_idx) * TW'(MAX_FEATURES)) + TW'(fb_idx);
    assign pair_addr = TW'(TW'(f1_reg[FW-1:0]) * TW'(MAX_FEATURES)) + TW'(f2_reg[FW-1:0]);
    assign sdiv     = (sample_count_reg == '0) ? CB'(1) : sample_count_reg;
    assign at_done  = (state_reg == cfps_pkg::ST_DONE);
    assign at_chk   = (state_reg == cfps_pkg::ST_W_CHK);

    // sample product, saturated to the accumulator width
    assign prod_full = PW'(fv_reg) * PW'(d_reg);
    assign prod_x    = XW'(prod_full);
    assign acc_cur   = acc_rvld_reg ? $signed(acc_rd_reg) : '0;
    assign sum_x     = (AB+1)'(acc_cur) + (AB+1)'(prod_reg);

    // covariance divider step (restoring, one bit a cycle)
    assign fd_trial = {drem_reg, dq_reg[AB-1]};
    assign fd_bit   = (fd_trial >= (CB+1)'(sdiv));

    // score divider
    assign n_full  = {m_reg, {cfps_pkg::FRAC_BITS{1'b0}}};
    assign n_hi    = RW'(n_full >> QW);
    assign w_trial = {rem_reg[RW-2:0], nlo_reg[QW-1]};
    assign w_bit   = (w_trial >= RW'(den_reg));
    assign q_new   = {q_reg[QW-2:0], w_bit};
    assign cov_b   = acc_rd_reg;

    // walk bookkeeping
    assign f1_p1 = (CW+1)'(f1_reg) + (CW+1)'(1);
    assign f1_p2 = (CW+1)'(f1_reg) + (CW+1)'(2);
    assign f2_p1 = (CW+1)'(f2_reg) + (CW+1)'(1);
    assign take  = ((f1_reg == '0) && (f2_reg == CW'(1))) || (score_reg > best_reg);

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == cfps_pkg::REG_SAMPLE_COUNT) ? 32'(sample_count_reg)
                                                             : 32'(feature_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feature_count_reg <= cfps_pkg::FEATURE_COUNT_RESET;
            sample_count_reg  <= cfps_pkg::SAMPLE_COUNT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == cfps_pkg::REG_FEATURE_COUNT)
                feature_count_reg <= pwdata[cfps_pkg::FC_BITS-1:0];
            else
                sample_count_reg <= pwdata[CB-1:0];
        end
    end

    // ---------------- memories ----------------
    always_ff @(posedge clk)
    begin
        if (sp_we)
            spread_mem[sp_waddr] <= pair_spread;
        spread_rd_reg <= spread_mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (used_we)
            used_mem[used_waddr] <= used_wdata;
        used_rd_reg <= used_mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
            acc_mem[acc_waddr] <= acc_wdata;
        acc_rd_reg <= acc_mem[acc_raddr];
    end

    // entries in the accumulator half read as zero until written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_rvld_reg <= 1'b0;
        else
            acc_rvld_reg <= acc_raddr[AW-1] | acc_vld_reg[acc_raddr[FW-1:0]];
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next       = state_reg;
        mean_next        = mean_reg;
        tspread_next     = tspread_reg;
        acc_vld_next     = acc_vld_reg;
        clr_next         = clr_reg;
        f1_next          = f1_reg;
        f2_next          = f2_reg;
        step_next        = step_reg;
        out_valid_next   = out_valid_reg;
        smp_f_next       = smp_f_reg;
        fv_next          = fv_reg;
        d_next           = d_reg;
        prod_next        = prod_reg;
        dq_next          = dq_reg;
        drem_next        = drem_reg;
        dneg_next        = dneg_reg;
        cov_a_next       = cov_a_reg;
        m_next           = m_reg;
        neg_next         = neg_reg;
        den_next         = den_reg;
        rem_next         = rem_reg;
        nlo_next         = nlo_reg;
        q_next           = q_reg;
        score_next       = score_reg;
        best_next        = best_reg;
        bf_next          = bf_reg;
        bs_next          = bs_reg;
        best_first_next  = best_first_reg;
        best_second_next = best_second_reg;
        best_score_next  = best_score_reg;
        sp_we            = 1'b0;
        sp_waddr         = load_addr;
        mem_raddr        = pair_addr;
        used_we          = 1'b0;
        used_waddr       = pair_addr;
        used_wdata       = 1'b1;
        acc_we           = 1'b0;
        acc_waddr        = {1'b0, smp_f_reg};
        acc_wdata        = '0;
        acc_raddr        = {1'b0, smp_f_reg};

        // result taken downstream
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            // clearing pass over the used map
            cfps_pkg::ST_CLR:
            begin
                used_we    = 1'b1;
                used_waddr = clr_reg;
                used_wdata = 1'b0;
                if (clr_reg == TW'(TD - 1))
                    state_next = cfps_pkg::ST_IDLE;
                else
                    clr_next = clr_reg + TW'(1);
            end

            cfps_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        cfps_pkg::ACT_LOAD:
                            sp_we = load_ok;
                        cfps_pkg::ACT_BATCH:
                        begin
                            clr_next   = '0;
                            state_next = cfps_pkg::ST_CLR;
                        end
                        cfps_pkg::ACT_TARGET:
                        begin
                            mean_next    = target_mean;
                            tspread_next = target_spread;
                            acc_vld_next = '0;
                        end
                        cfps_pkg::ACT_SAMPLE:
                        begin
                            if (smp_ok)
                            begin
                                smp_f_next = fa_idx;
                                fv_next    = feature_value;
                                d_next     = (VB+1)'(target_value) - (VB+1)'(mean_reg);
                                acc_raddr  = {1'b0, fa_idx};
                                state_next = cfps_pkg::ST_SMP_MUL;
                            end
                        end
                        cfps_pkg::ACT_FINISH:
                        begin
                            best_next = '0;
                            bf_next   = '0;
                            bs_next   = '0;
                            f1_next   = '0;
                            if (fc_eff < CW'(2))
                                state_next = cfps_pkg::ST_DONE;
                            else
                                state_next = cfps_pkg::ST_FD_RD;
                        end
                        default:
                            state_next = cfps_pkg::ST_IDLE;
                    endcase
                end
            end

            // sample: multiply while the accumulator is read
            cfps_pkg::ST_SMP_MUL:
            begin
                if ((prod_x[XW-1:AB-1] == '0) || (prod_x[XW-1:AB-1] == '1))
                    prod_next = prod_x[AB-1:0];
                else
                    prod_next = prod_x[XW-1] ? {1'b1, {(AB-1){1'b0}}}
                                             : {1'b0, {(AB-1){1'b1}}};
                state_next = cfps_pkg::ST_SMP_ADD;
            end

            // sample: saturating add and write back
            cfps_pkg::ST_SMP_ADD:
            begin
                acc_we = 1'b1;
                if (sum_x[AB] == sum_x[AB-1])
                    acc_wdata = sum_x[AB-1:0];
                else
                    acc_wdata = sum_x[AB] ? {1'b1, {(AB-1){1'b0}}}
                                          : {1'b0, {(AB-1){1'b1}}};
                acc_vld_next[smp_f_reg] = 1'b1;
                state_next = cfps_pkg::ST_IDLE;
            end

            // covariance per feature
            cfps_pkg::ST_FD_RD:
            begin
                acc_raddr  = {1'b0, f1_reg[FW-1:0]};
                state_next = cfps_pkg::ST_FD_LD;
            end

            cfps_pkg::ST_FD_LD:
            begin
                dneg_next  = acc_cur[AB-1];
                dq_next    = acc_cur[AB-1] ? (AB'(0) - AB'(acc_cur)) : AB'(acc_cur);
                drem_next  = '0;
                step_next  = '1;
                state_next = cfps_pkg::ST_FD_DIV;
            end

            cfps_pkg::ST_FD_DIV:
            begin
                drem_next = fd_bit ? CB'(fd_trial - (CB+1)'(sdiv)) : CB'(fd_trial);
                dq_next   = {dq_reg[AB-2:0], fd_bit};
                if (step_reg == '0)
                    state_next = cfps_pkg::ST_FD_WR;
                else
                    step_next = step_reg - SW'(1);
            end

            cfps_pkg::ST_FD_WR:
            begin
                acc_we    = 1'b1;
                acc_waddr = {1'b1, f1_reg[FW-1:0]};
                acc_wdata = dneg_reg ? (AB'(0) - dq_reg) : dq_reg;
                if (f1_reg == fc_eff - CW'(1))
                begin
                    f1_next    = '0;
                    f2_next    = CW'(1);
                    state_next = cfps_pkg::ST_W_RD1;
                end
                else
                begin
                    f1_next    = CW'(f1_p1);
                    state_next = cfps_pkg::ST_FD_RD;
                end
            end

            // pair walk
            cfps_pkg::ST_W_RD1:
            begin
                acc_raddr  = {1'b1, f1_reg[FW-1:0]};
                state_next = cfps_pkg::ST_W_LD1;
            end

            cfps_pkg::ST_W_LD1:
            begin
                cov_a_next = acc_rd_reg;
                state_next = cfps_pkg::ST_W_RD2;
            end

            cfps_pkg::ST_W_RD2:
            begin
                acc_raddr  = {1'b1, f2_reg[FW-1:0]};
                state_next = cfps_pkg::ST_W_CHK;
            end

            cfps_pkg::ST_W_CHK:
            begin
                if (used_rd_reg)
                    state_next = cfps_pkg::ST_W_CMP;
                else
                begin
                    neg_next   = (cov_a_reg < $signed(cov_b));
                    m_next     = (cov_a_reg < $signed(cov_b)) ? (cov_b - AB'(cov_a_reg))
                                                              : (AB'(cov_a_reg) - cov_b);
                    den_next   = DW'(spread_rd_reg) * DW'(tspread_reg);
                    state_next = cfps_pkg::ST_W_OVF;
                end
            end

            // zero, saturation, or set up the long division
            cfps_pkg::ST_W_OVF:
            begin
                if (m_reg == '0)
                begin
                    score_next = '0;
                    state_next = cfps_pkg::ST_W_CMP;
                end
                else if (n_hi >= RW'(den_reg))
                begin
                    score_next = neg_reg ? {1'b1, {(VB-1){1'b0}}} : {1'b0, {(VB-1){1'b1}}};
                    state_next = cfps_pkg::ST_W_CMP;
                end
                else
                begin
                    rem_next   = n_hi;
                    nlo_next   = n_full[QW-1:0];
                    q_next     = '0;
                    step_next  = SW'(QW - 1);
                    state_next = cfps_pkg::ST_W_DIV;
                end
            end

            cfps_pkg::ST_W_DIV:
            begin
                rem_next = w_bit ? (w_trial - RW'(den_reg)) : w_trial;
                nlo_next = {nlo_reg[QW-2:0], 1'b0};
                q_next   = q_new;
                if (step_reg == '0)
                begin
                    score_next = neg_reg ? (VB'(0) - VB'(q_new)) : VB'(q_new);
                    state_next = cfps_pkg::ST_W_CMP;
                end
                else
                    step_next = step_reg - SW'(1);
            end

            // compare (skipped pairs pass through without update) and advance
            cfps_pkg::ST_W_CMP:
            begin
                if (!used_rd_reg && take)
                begin
                    best_next = score_reg;
                    bf_next   = cfps_pkg::PAIR_BITS'(f1_p1);
                    bs_next   = cfps_pkg::PAIR_BITS'(f2_p1);
                    used_we   = 1'b1;
                end
                if (f2_p1 < (CW+1)'(fc_eff))
                begin
                    f2_next    = CW'(f2_p1);
                    state_next = cfps_pkg::ST_W_RD2;
                end
                else if (f1_p2 < (CW+1)'(fc_eff))
                begin
                    f1_next    = CW'(f1_p1);
                    f2_next    = CW'(f1_p2);
                    state_next = cfps_pkg::ST_W_RD1;
                end
                else
                    state_next = cfps_pkg::ST_DONE;
            end

            // hand the result to the output register
            cfps_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    best_first_next  = bf_reg;
                    best_second_next = bs_reg;
                    best_score_next  = best_reg;
                    state_next       = cfps_pkg::ST_IDLE;
                end
            end

            default:
                state_next = cfps_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfps_pkg::ST_CLR;
            mean_reg      <= '0;
            tspread_reg   <= '0;
            acc_vld_reg   <= '0;
            clr_reg       <= '0;
            f1_reg        <= '0;
            f2_reg        <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mean_reg      <= mean_next;
            tspread_reg   <= tspread_next;
            acc_vld_reg   <= acc_vld_next;
            clr_reg       <= clr_next;
            f1_reg        <= f1_next;
            f2_reg        <= f2_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        smp_f_reg       <= smp_f_next;
        fv_reg          <= fv_next;
        d_reg           <= d_next;
        prod_reg        <= prod_next;
        dq_reg          <= dq_next;
        drem_reg        <= drem_next;
        dneg_reg        <= dneg_next;
        cov_a_reg       <= cov_a_next;
        m_reg           <= m_next;
        neg_reg         <= neg_next;
        den_reg         <= den_next;
        rem_reg         <= rem_next;
        nlo_reg         <= nlo_next;
        q_reg           <= q_next;
        score_reg       <= score_next;
        best_reg        <= best_next;
        bf_reg          <= bf_next;
        bs_reg          <= bs_next;
        best_first_reg  <= best_first_next;
        best_second_reg <= best_second_next;
        best_score_reg  <= best_score_next;
    end

    assign out_valid   = out_valid_reg;
    assign best_first  = best_first_reg;
    assign best_second = best_second_reg;
    assign best_score  = best_score_reg;

    // ---------------- checks ----------------
    `CFPS_ASSERT_IMP(a_accept_idle, clk, rst_n, accept, (state_reg == cfps_pkg::ST_IDLE))
    `CFPS_ASSERT_NXT(a_out_from_done, clk, rst_n, (!out_valid_reg && !at_done), !out_valid_reg)
    `CFPS_ASSERT_IMP(a_walk_order, clk, rst_n, at_chk, ((f1_reg < f2_reg) && (f2_reg < fc_eff)))

endmodule
